// ----- design/lrt_pkg.sv -----
// Shared types and constants for the launch extent range table.
package lrt_pkg;

  // Table geometry.
  localparam int MAX_EXTENTS = 16;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = IDX_W + 1;

  // Page geometry.
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  // Field widths.
  localparam int ADDR_W  = 52;
  localparam int SIZE_W  = 32;
  localparam int LIMIT_W = ADDR_W + 1;
  localparam int VB_W    = 13;
  localparam int OIDX_W  = 4;

  // Operation codes carried in the mode field.
  typedef enum logic [1:0] {
    MODE_ADD      = 2'd0,
    MODE_CONTAINS = 2'd1,
    MODE_PAGE     = 2'd2,
    MODE_LIMIT    = 2'd3
  } mode_t;

  // Request word.
  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] data_size;
    logic [SIZE_W-1:0] total_size;
    logic              has_data;
  } req_word_t;

  // Response word.
  typedef struct packed {
    logic               found;
    logic [OIDX_W-1:0]  extent_index;
    logic [SIZE_W-1:0]  data_offset;
    logic [VB_W-1:0]    valid_bytes;
    logic [LIMIT_W-1:0] end_limit;
    logic               add_dropped;
  } rsp_word_t;

  // One stored extent.
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] data_bytes;
    logic [SIZE_W-1:0] total_bytes;
  } extent_t;

  localparam int EXTENT_W = $bits(extent_t);

  // Status returned by the compare unit for one extent.
  typedef struct packed {
    logic               hit;
    logic               greater;
    logic [LIMIT_W-1:0] end_addr;
  } scan_res_t;

endpackage

// ----- design/lrt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module lrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/lrt_scan_unit.sv -----
// Shared compare unit: extent end, containment test and running maximum test.
module lrt_scan_unit import lrt_pkg::*; (
  input  extent_t             entry,
  input  logic [ADDR_W-1:0]   key,
  input  logic [LIMIT_W-1:0]  lim,
  output scan_res_t           res
);

  logic [LIMIT_W-1:0] end_addr;

  // The end is formed one bit wider so that it never wraps.
  assign end_addr = {1'b0, entry.base} + {{(LIMIT_W-SIZE_W){1'b0}}, entry.total_bytes};

  // The key lies in the extent when base <= key < end.
  always_comb begin
    res.end_addr = end_addr;
    res.hit      = (key >= entry.base) && ({1'b0, key} < end_addr);
    res.greater  = end_addr > lim;
  end

endmodule

// ----- design/launch_extent_range_table.sv -----
// Top level of the launch extent range table: sequencer, table and result register.
//
//  channel | direction | handshake          | word
//  req     | in        | req_valid/req_stall | req_word_t
//  rsp     | out       | rsp_valid/rsp_stall | rsp_word_t
//
// An add passes from acceptance through the start state to the result register. A query walks
// the table through the one read port of the extent RAM, one entry a cycle, and a
// hit ends a contains or page query early; a page query then goes through the offset
// and valid-bytes states before the result.
// Reset empties the table at once; stored entries are not cleared.
// req_stall is high from acceptance until the result is loaded, which waits while
// the result register still holds a word that is stalled.
module launch_extent_range_table import lrt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_START  = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_PG_OFF = 6'b001000,
    ST_PG_VB  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t             state;
  state_t             state_next;
  req_word_t          item;
  logic [CNT_W-1:0]   extent_count;
  logic [CNT_W-1:0]   rd_idx;
  logic               ev_valid;
  logic [IDX_W-1:0]   ev_idx;
  logic               res_found;
  logic [IDX_W-1:0]   res_idx;
  logic [SIZE_W-1:0]  res_off;
  logic [VB_W-1:0]    res_vb;
  logic               res_drop;
  logic [LIMIT_W-1:0] lim;
  logic [ADDR_W-1:0]  hit_base;
  logic [SIZE_W-1:0]  hit_data;

  logic               accept;
  logic               issue;
  logic               add_ok;
  logic               out_free;
  logic [ADDR_W-1:0]  page;
  logic [ADDR_W-1:0]  key;
  extent_t            wr_entry;
  extent_t            rd_entry;
  logic [EXTENT_W-1:0] rd_bits;
  scan_res_t          scan;
  logic [SIZE_W-1:0]  diff;
  mode_t              mode;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign mode      = mode_t'(item.mode);

  // The page query matches the page-aligned address.
  assign page = {item.address[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
  assign key  = (mode == MODE_PAGE) ? page : item.address;

  // Extent store.
  assign add_ok   = (state == ST_START) && (mode == MODE_ADD) &&
                    (item.total_size != '0) && (extent_count < CNT_W'(MAX_EXTENTS));
  assign issue    = (state == ST_SCAN) && (rd_idx < extent_count);
  assign wr_entry = '{base:        item.address,
                      data_bytes:  item.has_data ? item.data_size : '0,
                      total_bytes: item.total_size};
  assign rd_entry = extent_t'(rd_bits);

  lrt_ram #(
    .WIDTH (EXTENT_W),
    .DEPTH (MAX_EXTENTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (add_ok),
    .wr_addr (extent_count[IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (rd_bits)
  );

  lrt_scan_unit u_scan (
    .entry (rd_entry),
    .key   (key),
    .lim   (lim),
    .res   (scan)
  );

  // Data bytes left in the extent from the page offset onwards.
  assign diff = hit_data - res_off;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_START;
      end
      ST_START: begin
        state_next = (mode == MODE_ADD) ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (ev_valid && scan.hit && (mode != MODE_LIMIT)) begin
          state_next = (mode == MODE_PAGE) ? ST_PG_OFF : ST_DONE;
        end else if (!issue && !ev_valid) begin
          state_next = ST_DONE;
        end
      end
      ST_PG_OFF: state_next = ST_PG_VB;
      ST_PG_VB:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      extent_count <= '0;
      ev_valid     <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (add_ok) begin
        extent_count <= extent_count + 1'b1;
      end
      ev_valid <= issue && (state_next == ST_SCAN);
      if (out_free) begin
        rsp_valid <= (state == ST_DONE);
      end
    end
  end

  // Item capture, scan bookkeeping and result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    ev_idx <= rd_idx[IDX_W-1:0];
    unique case (state)
      ST_START: begin
        rd_idx    <= '0;
        lim       <= '0;
        res_found <= 1'b0;
        res_idx   <= '0;
        res_off   <= '0;
        res_vb    <= '0;
        res_drop  <= (mode == MODE_ADD) && (item.total_size != '0) &&
                     (extent_count >= CNT_W'(MAX_EXTENTS));
      end
      ST_SCAN: begin
        if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (ev_valid && (mode == MODE_LIMIT) && scan.greater) begin
          lim <= scan.end_addr;
        end
        if (ev_valid && scan.hit && (mode != MODE_LIMIT)) begin
          res_found <= 1'b1;
          res_idx   <= ev_idx;
          hit_base  <= rd_entry.base;
          hit_data  <= rd_entry.data_bytes;
        end
      end
      ST_PG_OFF: begin
        // The page lies inside the extent, so the offset fits in the size width.
        res_off <= SIZE_W'(page - hit_base);
      end
      ST_PG_VB: begin
        if (res_off < hit_data) begin
          res_vb <= (diff > SIZE_W'(PAGE_BYTES)) ? VB_W'(PAGE_BYTES) : diff[VB_W-1:0];
        end else begin
          res_vb <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: loaded when the sequencer is done and the register is free.
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      rsp.found        <= res_found;
      rsp.extent_index <= OIDX_W'(res_idx);
      rsp.data_offset  <= res_off;
      rsp.valid_bytes  <= res_vb;
      rsp.end_limit    <= (mode == MODE_LIMIT) ? lim : '0;
      rsp.add_dropped  <= res_drop;
    end
  end

endmodule

// ----- verif/lrt_tb_pkg.sv -----
// Scoreboard class for the launch extent range table testbench.
package lrt_tb_pkg;
  import lrt_pkg::*;

  class extent_table_checker;
    // Shadow copy of the extent table, in insertion order.
    extent_t     extents [MAX_EXTENTS];
    int unsigned n_extents;
    // Response words still owed by the block, oldest first.
    rsp_word_t   answers_due [$];
    int unsigned errors;

    function new();
      n_extents = 0;
      errors    = 0;
    endfunction

    function int unsigned outstanding();
      return answers_due.size();
    endfunction

    // Index of the first extent that holds the address, or -1 when none does.
    function int first_hit(logic [ADDR_W-1:0] a);
      logic [LIMIT_W-1:0] stop;
      for (int i = 0; i < n_extents; i++) begin
        stop = extents[i].base + extents[i].total_bytes;
        if (a >= extents[i].base && a < stop) return i;
      end
      return -1;
    endfunction

    // Work out the response to an accepted request word and update the shadow table.
    function void note_request(req_word_t w);
      rsp_word_t          ans;
      logic [ADDR_W-1:0]  page;
      logic [ADDR_W-1:0]  off;
      logic [ADDR_W-1:0]  room;
      logic [LIMIT_W-1:0] stop;
      int                 k;
      ans = '0;
      case (mode_t'(w.mode))
        MODE_ADD: begin
          // A zero-sized extent is ignored even when the table is full.
          if (w.total_size != '0) begin
            if (n_extents >= MAX_EXTENTS) begin
              ans.add_dropped = 1'b1;
            end else begin
              extents[n_extents].base        = w.address;
              extents[n_extents].data_bytes  = w.has_data ? w.data_size : '0;
              extents[n_extents].total_bytes = w.total_size;
              n_extents++;
            end
          end
        end
        MODE_CONTAINS: begin
          k = first_hit(w.address);
          if (k >= 0) begin
            ans.found        = 1'b1;
            ans.extent_index = k[OIDX_W-1:0];
          end
        end
        MODE_PAGE: begin
          // The aligned page address is what gets matched, not the raw one.
          page = {w.address[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
          k    = first_hit(page);
          if (k >= 0) begin
            off              = page - extents[k].base;
            ans.found        = 1'b1;
            ans.extent_index = k[OIDX_W-1:0];
            ans.data_offset  = off[SIZE_W-1:0];
            if (off < extents[k].data_bytes) begin
              room = extents[k].data_bytes - off;
              if (room > ADDR_W'(PAGE_BYTES)) room = ADDR_W'(PAGE_BYTES);
              ans.valid_bytes = room[VB_W-1:0];
            end
          end
        end
        default: begin
          // Greatest extent end, at the wider width so it never wraps.
          for (int i = 0; i < n_extents; i++) begin
            stop = extents[i].base + extents[i].total_bytes;
            if (stop > ans.end_limit) ans.end_limit = stop;
          end
        end
      endcase
      answers_due.push_back(ans);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    // Compare an accepted response word with the oldest one owed.
    function void check_answer(rsp_word_t r);
      rsp_word_t want;
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: response word 0x%0h arrived with none expected", $time, r);
        return;
      end
      want = answers_due.pop_front();
      compare_field("found", want.found, r.found);
      compare_field("extent_index", want.extent_index, r.extent_index);
      compare_field("data_offset", want.data_offset, r.data_offset);
      compare_field("valid_bytes", want.valid_bytes, r.valid_bytes);
      compare_field("end_limit", want.end_limit, r.end_limit);
      compare_field("add_dropped", want.add_dropped, r.add_dropped);
    endfunction
  endclass

endpackage

// ----- verif/tb.sv -----
// Self-checking testbench for the launch extent range table.
module tb;
  import lrt_pkg::*;
  import lrt_tb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_WORDS = 1200;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;

  extent_table_checker sb = new();
  bit                  calm = 1'b0;
  int unsigned         cycle_count;
  int                  stall_left = 0;

  launch_extent_range_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Gap length for either side: mostly short, now and then long.
  function int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Response side: check accepted words, then choose the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_answer(rsp);
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 30) begin
      rsp_stall <= 1'b1;
      stall_left = gap_length();
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("launch_extent_range_table regression: fail");
    $finish;
  end

  function req_word_t make_req(mode_t m, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] d,
                               logic [SIZE_W-1:0] t, logic h);
    req_word_t w;
    w.mode       = m;
    w.address    = a;
    w.data_size  = d;
    w.total_size = t;
    w.has_data   = h;
    return w;
  endfunction

  // Offer one request word, hold it until accepted, then idle for a while.
  task automatic drive_req(req_word_t w);
    int unsigned n;
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (req_stall);
    sb.note_request(w);
    n = gap_length();
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending until every owed response has come back.
  task automatic wait_drained();
    while (sb.outstanding() != 0) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Query address: mostly near the edges of a stored extent, some pure noise.
  function logic [ADDR_W-1:0] pick_address();
    logic [LIMIT_W-1:0] a;
    extent_t            e;
    int unsigned        k;
    if (sb.n_extents == 0 || $urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0:       a = '0;
        1:       a = {1'b0, {ADDR_W{1'b1}}};
        default: a = LIMIT_W'({$urandom, $urandom});
      endcase
    end else begin
      k = $urandom_range(0, sb.n_extents - 1);
      e = sb.extents[k];
      case ($urandom_range(0, 5))
        0:       a = e.base;
        1:       a = e.base + e.total_bytes - 1;
        2:       a = e.base + e.total_bytes;
        3:       a = e.base - 1;
        4:       a = e.base + $urandom_range(0, e.total_bytes - 1);
        default: a = e.base + e.data_bytes + $urandom_range(0, 8191) - 4096;
      endcase
    end
    return a[ADDR_W-1:0];
  endfunction

  // New extent: most land in one small window so that they overlap.
  function req_word_t random_extent();
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] tot;
    logic [SIZE_W-1:0] dat;
    int unsigned       r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      base = 52'h40_0000 + $urandom_range(0, 'h3_FFFF);
      if ($urandom_range(0, 1) == 1) base[PAGE_SHIFT-1:0] = '0;
    end else if (r < 85) begin
      base = ADDR_W'({$urandom, $urandom});
    end else if (r < 95) begin
      base = {ADDR_W{1'b1}} - $urandom_range(0, 'hFFFF);
    end else begin
      base = '0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) tot = $urandom_range(1, 'h1_0000);
    else if (r < 80) tot = $urandom_range(1, 'h40_0000);
    else if (r < 95) tot = $urandom;
    else tot = '0;
    r = $urandom_range(0, 99);
    if (r < 30) dat = $urandom_range(0, tot);
    else if (r < 60) dat = $urandom;
    else if (r < 80) dat = '0;
    else dat = tot + $urandom_range(0, 'h2000);
    return make_req(MODE_ADD, base, dat, tot, 1'($urandom_range(0, 1)));
  endfunction

  function req_word_t random_query(mode_t m);
    return make_req(m, pick_address(), $urandom, $urandom, 1'($urandom_range(0, 1)));
  endfunction

  initial begin
    int unsigned r;
    int unsigned add_pct;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed words: empty table, overlapping extents, page edge cases.
    drive_req(make_req(MODE_LIMIT, '0, '0, '0, 1'b0));
    drive_req(make_req(MODE_CONTAINS, '0, '1, '1, 1'b1));
    drive_req(make_req(MODE_PAGE, '1, '0, '0, 1'b0));
    drive_req(make_req(MODE_ADD, '1, '1, '0, 1'b1));
    drive_req(make_req(MODE_ADD, 52'h1800, 32'h2345, 32'h5000, 1'b1));
    drive_req(make_req(MODE_ADD, 52'h1000, 32'h1_0000, 32'h3000, 1'b0));
    drive_req(make_req(MODE_ADD, '1, '1, '1, 1'b1));
    drive_req(make_req(MODE_ADD, 52'h10_0000, 32'h1800, 32'h4000, 1'b1));
    drive_req(make_req(MODE_CONTAINS, 52'h1800, '0, '0, 1'b0));
    drive_req(make_req(MODE_CONTAINS, 52'h17FF, '0, '0, 1'b0));
    drive_req(make_req(MODE_CONTAINS, 52'h6800, '0, '0, 1'b0));
    drive_req(make_req(MODE_CONTAINS, 52'h67FF, '0, '0, 1'b0));
    drive_req(make_req(MODE_PAGE, 52'h1ABC, '0, '0, 1'b0));
    drive_req(make_req(MODE_PAGE, 52'h4123, '0, '0, 1'b0));
    drive_req(make_req(MODE_PAGE, 52'h2FFF, '0, '0, 1'b0));
    drive_req(make_req(MODE_PAGE, 52'h3000, '0, '0, 1'b0));
    drive_req(make_req(MODE_PAGE, 52'h10_1FFF, '1, '1, 1'b1));
    drive_req(make_req(MODE_PAGE, '1, '0, '0, 1'b0));
    drive_req(make_req(MODE_CONTAINS, '1, '0, '0, 1'b0));
    drive_req(make_req(MODE_LIMIT, '1, '1, '1, 1'b1));
    drive_req(make_req(MODE_CONTAINS, '0, '0, '0, 1'b0));
    wait_drained();

    // Random words: queries dominate while the table fills slowly; adds pile up at the end.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i % 150 == 149) wait_drained();
      add_pct = (i >= RANDOM_WORDS - 100) ? 40 : 4;
      r = $urandom_range(0, 99);
      if (r < add_pct) begin
        drive_req(random_extent());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) drive_req(random_query(MODE_CONTAINS));
        else if (r < 90) drive_req(random_query(MODE_PAGE));
        else drive_req(random_query(MODE_LIMIT));
      end
    end

    // Make sure the table is full, then try both kinds of add against it.
    calm = 1'b0;
    while (sb.n_extents < MAX_EXTENTS) drive_req(random_extent());
    drive_req(make_req(MODE_ADD, '0, '0, '0, 1'b0));
    drive_req(make_req(MODE_ADD, '1, '1, '1, 1'b1));
    drive_req(make_req(MODE_LIMIT, '0, '0, '0, 1'b0));
    drive_req(random_query(MODE_CONTAINS));
    drive_req(random_query(MODE_PAGE));

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("launch_extent_range_table regression: pass");
    end else begin
      $display("launch_extent_range_table regression: fail");
    end
    $finish;
  end

endmodule
